/* sv/aoc_pkg.sv */
// package: pixel item types and widths for the alpha over compositor
`default_nettype none

package aoc_pkg;

    localparam int ChW = 8;
    localparam int ChMax = 255;
    localparam int Colours = 3;
    localparam int WeightW = 2 * ChW;
    localparam int ProdW = 3 * ChW;
    localparam int DvdW = ProdW + 1;
    localparam int DvsW = WeightW + 1;
    localparam int BitsPerStage = 2;
    localparam int DivStages = ChW / BitsPerStage;
    localparam int FrontStages = 3;
    localparam int Stages = FrontStages + DivStages;
    localparam int AlphaBias = ChMax / 2;

    typedef struct packed {
        logic [ChW-1:0] fg_blue;
        logic [ChW-1:0] fg_green;
        logic [ChW-1:0] fg_red;
        logic [ChW-1:0] fg_alpha;
        logic [ChW-1:0] bg_blue;
        logic [ChW-1:0] bg_green;
        logic [ChW-1:0] bg_red;
        logic [ChW-1:0] bg_alpha;
    } pix_in_t;

    typedef struct packed {
        logic [ChW-1:0] out_blue;
        logic [ChW-1:0] out_green;
        logic [ChW-1:0] out_red;
        logic [ChW-1:0] out_alpha;
    } pix_out_t;

endpackage

`default_nettype wire

/* sv/alpha_over_compositor.sv */
// top level: pipelined porter-duff over of two straight-alpha bgra pixels
//
// src channel takes one item of foreground and background pixels, dst
// channel returns one composited pixel per item. each channel uses
// valid and stall; an item moves on an edge with valid high and stall low.
// the pipeline is seven register stages deep: weights, products, dividend
// set-up and alpha, then four divider stages resolving two quotient bits
// each. an item passes the stages in that order, and dst_valid is the valid
// bit of the last divider stage.
// throughput is one item per clock while dst is not stalled; the restoring
// divider lanes (three colours) each advance one stage per cycle unless held.
// colour is round-half-up of the alpha-weighted mean, alpha is rounded
// af + ab*(255-af)/255 by shift and add; with both alphas zero the result
// is all zero.
// reset clears only the stage valid bits, so the block comes up empty.
// when dst stalls, stages that hold an item keep it, empty stages still
// fill, and src stall rises only once every stage ahead is occupied.
`default_nettype none

module alpha_over_compositor (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             src_valid,
    output      logic             src_stall,
    input  wire aoc_pkg::pix_in_t src_data,
    output      logic             dst_valid,
    input  wire logic             dst_stall,
    output      aoc_pkg::pix_out_t dst_data
);

    logic [aoc_pkg::Stages-1:0] valid_reg;
    logic [aoc_pkg::Stages-1:0] valid_next;
    logic [aoc_pkg::Stages:0]   adv;

    // stage 1: weights
    logic [aoc_pkg::ChW-1:0]     s1_cf_reg [aoc_pkg::Colours];
    logic [aoc_pkg::ChW-1:0]     s1_cb_reg [aoc_pkg::Colours];
    logic [aoc_pkg::WeightW-1:0] s1_fw_reg, s1_fw_next;
    logic [aoc_pkg::WeightW-1:0] s1_bw_reg, s1_bw_next;

    // stage 2: products
    logic [aoc_pkg::ProdW-1:0]   s2_pf_reg [aoc_pkg::Colours];
    logic [aoc_pkg::ProdW-1:0]   s2_pb_reg [aoc_pkg::Colours];
    logic [aoc_pkg::ProdW-1:0]   s2_pf_next [aoc_pkg::Colours];
    logic [aoc_pkg::ProdW-1:0]   s2_pb_next [aoc_pkg::Colours];
    logic [aoc_pkg::WeightW-1:0] s2_den_reg, s2_den_next;

    // stage 3: dividend and divisor per colour lane, alpha
    logic [aoc_pkg::DvdW-1:0] s3_rem_reg  [aoc_pkg::Colours];
    logic [aoc_pkg::DvsW-1:0] s3_dvs_reg  [aoc_pkg::Colours];
    logic [aoc_pkg::DvdW-1:0] s3_rem_next [aoc_pkg::Colours];
    logic [aoc_pkg::DvsW-1:0] s3_dvs_next [aoc_pkg::Colours];
    logic [aoc_pkg::ChW-1:0]  s3_alpha_reg, s3_alpha_next;
    logic                     s3_zero_reg, s3_zero_next;

    // handshake chain
    always_comb
    begin
        adv[aoc_pkg::Stages] = !dst_stall;
        for (int k = aoc_pkg::Stages - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        if (adv[0])
        begin
            valid_next[0] = src_valid;
        end
        else
        begin
            valid_next[0] = valid_reg[0];
        end
        for (int k = 1; k < aoc_pkg::Stages; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    assign src_stall = !adv[0];
    assign dst_valid = valid_reg[aoc_pkg::Stages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage 1
    always_comb
    begin
        s1_fw_next = {src_data.fg_alpha, {aoc_pkg::ChW{1'b0}}}
                   - {{aoc_pkg::ChW{1'b0}}, src_data.fg_alpha};
        s1_bw_next = {{aoc_pkg::ChW{1'b0}}, src_data.bg_alpha}
                   * {{aoc_pkg::ChW{1'b0}}, ~src_data.fg_alpha};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_cf_reg[0] <= src_data.fg_blue;
            s1_cf_reg[1] <= src_data.fg_green;
            s1_cf_reg[2] <= src_data.fg_red;
            s1_cb_reg[0] <= src_data.bg_blue;
            s1_cb_reg[1] <= src_data.bg_green;
            s1_cb_reg[2] <= src_data.bg_red;
            s1_fw_reg    <= s1_fw_next;
            s1_bw_reg    <= s1_bw_next;
        end
    end

    // stage 2
    always_comb
    begin
        for (int c = 0; c < aoc_pkg::Colours; c++)
        begin
            s2_pf_next[c] = {{aoc_pkg::WeightW{1'b0}}, s1_cf_reg[c]}
                          * {{aoc_pkg::ChW{1'b0}}, s1_fw_reg};
            s2_pb_next[c] = {{aoc_pkg::WeightW{1'b0}}, s1_cb_reg[c]}
                          * {{aoc_pkg::ChW{1'b0}}, s1_bw_reg};
        end
        s2_den_next = aoc_pkg::WeightW'({1'b0, s1_fw_reg} + {1'b0, s1_bw_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_pf_reg  <= s2_pf_next;
            s2_pb_reg  <= s2_pb_next;
            s2_den_reg <= s2_den_next;
        end
    end

    // stage 3: 2*num + den over 2*den, alpha is (den + 127) / 255 by shift and add
    always_comb
    begin
        logic [aoc_pkg::DvdW-1:0]    num;
        logic [aoc_pkg::WeightW-1:0] asum;
        for (int c = 0; c < aoc_pkg::Colours; c++)
        begin
            num = {1'b0, s2_pf_reg[c]} + {1'b0, s2_pb_reg[c]};
            s3_rem_next[c] = {num[aoc_pkg::DvdW-2:0], 1'b0}
                           + aoc_pkg::DvdW'(s2_den_reg);
            s3_dvs_next[c] = {s2_den_reg, 1'b0};
        end
        asum = s2_den_reg + aoc_pkg::WeightW'(aoc_pkg::AlphaBias);
        asum = asum + (asum >> aoc_pkg::ChW) + aoc_pkg::WeightW'(1);
        s3_alpha_next = asum[aoc_pkg::WeightW-1:aoc_pkg::ChW];
        s3_zero_next = (s2_den_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_rem_reg   <= s3_rem_next;
            s3_dvs_reg   <= s3_dvs_next;
            s3_alpha_reg <= s3_alpha_next;
            s3_zero_reg  <= s3_zero_next;
        end
    end

    // restoring division, two quotient bits per stage
    for (genvar gs = 0; gs < aoc_pkg::DivStages; gs++)
    begin : g_div
        logic [aoc_pkg::DvdW-1:0] rem_in   [aoc_pkg::Colours];
        logic [aoc_pkg::DvsW-1:0] dvs_in   [aoc_pkg::Colours];
        logic [aoc_pkg::ChW-1:0]  quo_in   [aoc_pkg::Colours];
        logic [aoc_pkg::ChW-1:0]  alpha_in;
        logic                     zero_in;
        logic [aoc_pkg::DvdW-1:0] rem_next [aoc_pkg::Colours];
        logic [aoc_pkg::ChW-1:0]  quo_next [aoc_pkg::Colours];
        logic [aoc_pkg::ChW-1:0]  quo_reg  [aoc_pkg::Colours];
        logic [aoc_pkg::ChW-1:0]  alpha_reg;
        logic                     zero_reg;

        if (gs == 0)
        begin : g_head
            always_comb
            begin
                rem_in   = s3_rem_reg;
                dvs_in   = s3_dvs_reg;
                quo_in   = '{default: '0};
                alpha_in = s3_alpha_reg;
                zero_in  = s3_zero_reg;
            end
        end
        else
        begin : g_tail
            always_comb
            begin
                rem_in   = g_div[gs-1].g_keep.rem_reg;
                dvs_in   = g_div[gs-1].g_keep.dvs_reg;
                quo_in   = g_div[gs-1].quo_reg;
                alpha_in = g_div[gs-1].alpha_reg;
                zero_in  = g_div[gs-1].zero_reg;
            end
        end

        always_comb
        begin
            logic [aoc_pkg::DvdW-1:0] r;
            logic [aoc_pkg::DvdW-1:0] d;
            logic [aoc_pkg::ChW-1:0]  q;
            int                       idx;
            for (int l = 0; l < aoc_pkg::Colours; l++)
            begin
                r = rem_in[l];
                q = quo_in[l];
                for (int b = 0; b < aoc_pkg::BitsPerStage; b++)
                begin
                    idx = aoc_pkg::ChW - 1 - aoc_pkg::BitsPerStage * gs - b;
                    d = aoc_pkg::DvdW'(dvs_in[l]) << idx;
                    if (r >= d)
                    begin
                        r = r - d;
                        q[idx[$clog2(aoc_pkg::ChW)-1:0]] = 1'b1;
                    end
                end
                rem_next[l] = r;
                quo_next[l] = q;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[aoc_pkg::FrontStages + gs])
            begin
                quo_reg   <= quo_next;
                alpha_reg <= alpha_in;
                zero_reg  <= zero_in;
            end
        end

        if (gs < aoc_pkg::DivStages - 1)
        begin : g_keep
            logic [aoc_pkg::DvdW-1:0] rem_reg [aoc_pkg::Colours];
            logic [aoc_pkg::DvsW-1:0] dvs_reg [aoc_pkg::Colours];

            always_ff @(posedge clk)
            begin
                if (adv[aoc_pkg::FrontStages + gs])
                begin
                    rem_reg <= rem_next;
                    dvs_reg <= dvs_in;
                end
            end
        end
    end

    // output
    always_comb
    begin
        logic zero;
        zero = g_div[aoc_pkg::DivStages-1].zero_reg;
        dst_data.out_blue  = zero ? '0 : g_div[aoc_pkg::DivStages-1].quo_reg[0];
        dst_data.out_green = zero ? '0 : g_div[aoc_pkg::DivStages-1].quo_reg[1];
        dst_data.out_red   = zero ? '0 : g_div[aoc_pkg::DivStages-1].quo_reg[2];
        dst_data.out_alpha = g_div[aoc_pkg::DivStages-1].alpha_reg;
    end

    // a free receiver never holds back the source
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !dst_stall |-> !src_stall)
        else $error("src stalled while dst is free");

    // an empty first stage always takes an item
    a_first_stage_open: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> !src_stall)
        else $error("src stalled with first stage empty");

    // zero result alpha only comes from a zero denominator
    a_clear_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_data.out_alpha == '0) |->
            (dst_data.out_blue == '0 && dst_data.out_green == '0
             && dst_data.out_red == '0))
        else $error("transparent result carries colour");

    // a stalled result stays in the last stage
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_stall) |=> dst_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire
